[sv/jhgc_pkg.sv]
// package: constants, jamo index tables and set selection for the glyph composer
package jhgc_pkg;

  // glyph geometry and region sizes
  localparam int unsigned GlyphRows  = 16;
  localparam int unsigned InitCount  = 19;
  localparam int unsigned MedCount   = 21;
  localparam int unsigned FinCount   = 27;
  localparam int unsigned InitSets   = 8;
  localparam int unsigned MedSets    = 4;
  localparam int unsigned FinSets    = 4;
  localparam int unsigned RowBits    = 4;

  // initial region lives in its own memory, medials and finals share the other
  localparam int unsigned InitDepth  = InitSets * InitCount * GlyphRows;
  localparam int unsigned MedDepth   = MedSets * MedCount * GlyphRows;
  localparam int unsigned FinDepth   = FinSets * FinCount * GlyphRows;
  localparam int unsigned VowDepth   = MedDepth + FinDepth;
  localparam int unsigned StoreDepth = InitDepth + VowDepth;
  localparam int unsigned MemAw      = 12;
  localparam int unsigned GlyphW     = MemAw - RowBits;
  localparam int unsigned FinGlyphOfs = MedSets * MedCount;

  // operation codes
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPOSE = 1'b1
  } op_e;

  // one composed row
  typedef struct packed {
    logic [15:0]        glyph_row;
    logic [RowBits-1:0] row_number;
    logic               last_row;
  } row_t;

  // initial jamo field to index, zero for fields with no meaning
  function automatic logic [4:0] init_index(input logic [4:0] f);
    logic [4:0] r;
    r = 5'd0;
    if (f >= 5'd2 && f <= 5'd20) r = f - 5'd1;
    return r;
  endfunction

  // medial jamo field to index
  function automatic logic [4:0] med_index(input logic [4:0] f);
    logic [4:0] r;
    r = 5'd0;
    if (f >= 5'd3 && f <= 5'd7) r = f - 5'd2;
    else if (f >= 5'd10 && f <= 5'd15) r = f - 5'd4;
    else if (f >= 5'd18 && f <= 5'd23) r = f - 5'd6;
    else if (f >= 5'd26 && f <= 5'd29) r = f - 5'd8;
    return r;
  endfunction

  // final jamo field to index
  function automatic logic [4:0] fin_index(input logic [4:0] f);
    logic [4:0] r;
    r = 5'd0;
    if (f >= 5'd2 && f <= 5'd17) r = f - 5'd1;
    else if (f >= 5'd19 && f <= 5'd29) r = f - 5'd2;
    return r;
  endfunction

  // initial set from medial index, without a final
  function automatic logic [2:0] init_set_open(input logic [4:0] m);
    logic [2:0] r;
    case (m)
      5'd9, 5'd13, 5'd19:         r = 3'd1;
      5'd14, 5'd18:               r = 3'd2;
      5'd10, 5'd11, 5'd12, 5'd20: r = 3'd3;
      5'd15, 5'd16, 5'd17:        r = 3'd4;
      default:                    r = 3'd0;
    endcase
    return r;
  endfunction

  // initial set from medial index, with a final
  function automatic logic [2:0] init_set_closed(input logic [4:0] m);
    logic [2:0] r;
    case (m)
      5'd9, 5'd13, 5'd14, 5'd18, 5'd19:               r = 3'd6;
      5'd10, 5'd11, 5'd12, 5'd15, 5'd16, 5'd17, 5'd20: r = 3'd7;
      default:                                        r = 3'd5;
    endcase
    return r;
  endfunction

  // final set from medial index
  function automatic logic [1:0] fin_set(input logic [4:0] m);
    logic [1:0] r;
    case (m)
      5'd5, 5'd7, 5'd12, 5'd15, 5'd17, 5'd20, 5'd21: r = 2'd1;
      5'd2, 5'd4, 5'd6, 5'd8, 5'd11, 5'd16:          r = 2'd2;
      5'd9, 5'd13, 5'd14, 5'd18, 5'd19:              r = 2'd3;
      default:                                      r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/jhgc_in_if.sv]
// input channel: font row writes and compose requests
interface jhgc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] code;
  logic [12:0] write_address;
  logic [15:0] write_data;

  modport source (output valid, operation, code, write_address, write_data, input ready);
  modport sink   (input valid, operation, code, write_address, write_data, output ready);
endinterface

[sv/jhgc_out_if.sv]
// output channel: composed glyph rows
interface jhgc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph_row;
  logic [3:0]  row_number;
  logic        last_row;

  modport source (output valid, glyph_row, row_number, last_row, input ready);
  modport sink   (input valid, glyph_row, row_number, last_row, output ready);
endinterface

[sv/johab_hangul_glyph_composer.sv]
// top level: Johab Hangul glyph composer with on-chip font store
// The font store is two synchronous memories: initial consonants (2432 rows)
// and medial vowels followed by final consonants (3072 rows, two read ports),
// so one glyph row of all three parts is read per cycle while the output slots
// have room. A write transfer loads one row and gives no output. A compose
// transfer produces 16 row transfers, one per cycle when the output is ready;
// the first row passes through the read registers and then the output register.
// The input stays not ready until the sixteenth read is issued, so a new request
// is not taken while a compose still issues reads, and output stalls delay it.
// Fonts must be loaded before composing; rows of absent parts are never used.
// Write addresses past the store are dropped.
module johab_hangul_glyph_composer (
  input  logic clk_i,
  input  logic rst_ni,
  jhgc_in_if.sink    req_i,
  jhgc_out_if.source rsp_o
);

  // font memories
  logic [15:0] init_mem [jhgc_pkg::InitDepth];
  logic [15:0] vow_mem  [jhgc_pkg::VowDepth];

  // per-glyph read setup
  logic                        issuing_q, issuing_d;
  logic [jhgc_pkg::RowBits-1:0] row_q, row_d;
  logic [jhgc_pkg::GlyphW-1:0] glyph_i_q, glyph_m_q, glyph_f_q;
  logic                        has_i_q, has_m_q, has_f_q;

  // read return and output slots
  logic                         rd_q;
  logic [jhgc_pkg::RowBits-1:0] rd_row_q;
  logic [15:0]                  rda_q, rdm_q, rdf_q;
  logic                         out_v_q, out_v_d, skid_v_q, skid_v_d;
  jhgc_pkg::row_t               out_q, out_d, skid_q, skid_d, land_row;

  logic accept, do_write, do_compose, issue, pop;
  logic [2:0] occ_next;

  // request decode
  logic [4:0] i1, i2, i3;
  logic [2:0] s1;
  logic [1:0] s2, s3;
  logic [jhgc_pkg::GlyphW-1:0] gi_new, gm_new, gf_new;
  logic [12:0] vow_addr_full;

  assign req_i.ready = !issuing_q;
  assign accept      = req_i.valid && req_i.ready;
  assign do_write    = accept && (req_i.operation == jhgc_pkg::OP_WRITE);
  assign do_compose  = accept && (req_i.operation == jhgc_pkg::OP_COMPOSE);

  // jamo indices, sets and glyph numbers
  always_comb begin
    i1 = jhgc_pkg::init_index(req_i.code[14:10]);
    i2 = jhgc_pkg::med_index(req_i.code[9:5]);
    i3 = jhgc_pkg::fin_index(req_i.code[4:0]);
    s1 = (i3 != 5'd0) ? jhgc_pkg::init_set_closed(i2) : jhgc_pkg::init_set_open(i2);
    s2 = {(i3 != 5'd0), !(i1 == 5'd0 || i1 == 5'd1 || i1 == 5'd16)};
    s3 = jhgc_pkg::fin_set(i2);
    gi_new = '0;
    gm_new = '0;
    gf_new = '0;
    if (i1 != 5'd0) begin
      gi_new = jhgc_pkg::GlyphW'(8'(s1) * 8'(jhgc_pkg::InitCount) + 8'(i1) - 8'd1);
    end
    if (i2 != 5'd0) begin
      gm_new = jhgc_pkg::GlyphW'(8'(s2) * 8'(jhgc_pkg::MedCount) + 8'(i2) - 8'd1);
    end
    if (i3 != 5'd0) begin
      gf_new = jhgc_pkg::GlyphW'(8'(jhgc_pkg::FinGlyphOfs) + 8'(s3) * 8'(jhgc_pkg::FinCount)
                                 + 8'(i3) - 8'd1);
    end
  end

  assign vow_addr_full = req_i.write_address - 13'(jhgc_pkg::InitDepth);

  // read credit: issue only when the returning row has a slot
  assign pop      = out_v_q && rsp_o.ready;
  assign occ_next = 3'(out_v_q) + 3'(skid_v_q) + 3'(rd_q) - 3'(pop);
  assign issue    = issuing_q && (occ_next <= 3'd1);

  // row sequencer
  always_comb begin
    issuing_d = issuing_q;
    row_d     = row_q;
    if (do_compose) begin
      issuing_d = 1'b1;
      row_d     = '0;
    end else if (issue) begin
      row_d = row_q + 1'b1;
      if (row_q == jhgc_pkg::RowBits'(jhgc_pkg::GlyphRows - 1)) begin
        issuing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      row_q     <= '0;
      rd_q      <= 1'b0;
      out_v_q   <= 1'b0;
      skid_v_q  <= 1'b0;
    end else begin
      issuing_q <= issuing_d;
      row_q     <= row_d;
      rd_q      <= issue;
      out_v_q   <= out_v_d;
      skid_v_q  <= skid_v_d;
    end
  end

  // glyph setup captured on a compose transfer
  always_ff @(posedge clk_i) begin
    if (do_compose) begin
      glyph_i_q <= gi_new;
      glyph_m_q <= gm_new;
      glyph_f_q <= gf_new;
      has_i_q   <= (i1 != 5'd0);
      has_m_q   <= (i2 != 5'd0);
      has_f_q   <= (i3 != 5'd0);
    end
    if (issue) begin
      rd_row_q <= row_q;
    end
  end

  // initial memory: write port and one read port
  always_ff @(posedge clk_i) begin
    if (do_write && (req_i.write_address < 13'(jhgc_pkg::InitDepth))) begin
      init_mem[req_i.write_address[jhgc_pkg::MemAw-1:0]] <= req_i.write_data;
    end
    if (issue) begin
      rda_q <= init_mem[{glyph_i_q, row_q}];
    end
  end

  // medial and final memory: write port and two read ports
  always_ff @(posedge clk_i) begin
    if (do_write && (req_i.write_address >= 13'(jhgc_pkg::InitDepth))
        && (req_i.write_address < 13'(jhgc_pkg::StoreDepth))) begin
      vow_mem[vow_addr_full[jhgc_pkg::MemAw-1:0]] <= req_i.write_data;
    end
    if (issue) begin
      rdm_q <= vow_mem[{glyph_m_q, row_q}];
      rdf_q <= vow_mem[{glyph_f_q, row_q}];
    end
  end

  // merge the present parts of the returning row
  always_comb begin
    land_row.glyph_row  = (has_i_q ? rda_q : 16'h0) | (has_m_q ? rdm_q : 16'h0)
                        | (has_f_q ? rdf_q : 16'h0);
    land_row.row_number = rd_row_q;
    land_row.last_row   = (rd_row_q == jhgc_pkg::RowBits'(jhgc_pkg::GlyphRows - 1));
  end

  // output register and skid slot
  always_comb begin
    out_d    = out_q;
    skid_d   = skid_q;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || pop) begin
      out_v_d = skid_v_q || rd_q;
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_d   = land_row;
        skid_v_d = rd_q;
      end else begin
        out_d    = land_row;
        skid_v_d = 1'b0;
      end
    end else if (rd_q) begin
      skid_d   = land_row;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.glyph_row  = out_q.glyph_row;
  assign rsp_o.row_number = out_q.row_number;
  assign rsp_o.last_row   = out_q.last_row;

endmodule
